>>> rtl/hill_cipher_block_multiply_defines.svh
// Assertion macros shared by the Hill cipher RTL.
`ifndef HILL_CIPHER_BLOCK_MULTIPLY_DEFINES_SVH
`define HILL_CIPHER_BLOCK_MULTIPLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hcbm_pkg.sv
`default_nettype none
package hcbm_pkg;

    localparam int LETTER_W      = 5;
    localparam int SIZE_W        = 3;
    localparam int KEY_W         = 20;
    localparam int KEY_ROWS      = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 20;
    localparam int MAX_BLOCK_DEF = 4;

    localparam logic [LETTER_W-1:0] ALPHA      = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd25;
    localparam logic [SIZE_W-1:0]   SIZE_RST   = 3'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BLOCK_SIZE = 3'd0,
        CFG_KEY_ROW_0  = 3'd1,
        CFG_KEY_ROW_1  = 3'd2,
        CFG_KEY_ROW_2  = 3'd3,
        CFG_KEY_ROW_3  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_in;
        logic                message_end;
    } in_word_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_out;
        logic                final_out;
    } out_word_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              last;
    } blk_ctl_t;

    // Reduces a 5-bit value that is below twice the alphabet size.
    function automatic logic [LETTER_W-1:0] mod_alpha(input logic [LETTER_W-1:0] v);
        return (v >= ALPHA) ? (v - ALPHA) : v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hcbm_collect.sv
`default_nettype none
`include "hill_cipher_block_multiply_defines.svh"
module hcbm_collect #(
    parameter int MAX_BLOCK = hcbm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  wire hcbm_pkg::in_word_t                          s_data,
    input  wire logic [hcbm_pkg::SIZE_W-1:0]                 eff_size,
    output logic                                             b_valid,
    input  wire logic                                        b_ready,
    output logic [MAX_BLOCK-1:0][hcbm_pkg::LETTER_W-1:0]     b_letters,
    output hcbm_pkg::blk_ctl_t                               b_ctl
);
    import hcbm_pkg::*;

    localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    logic [MAX_BLOCK-1:0][LETTER_W-1:0] store_reg;
    logic [SIZE_W-1:0]                  fill_reg;
    logic [SIZE_W-1:0]                  fill_inc;
    logic                               b_valid_reg;
    logic [MAX_BLOCK-1:0][LETTER_W-1:0] b_letters_reg;
    logic [MAX_BLOCK-1:0][LETTER_W-1:0] b_letters_next;
    blk_ctl_t                           b_ctl_reg;
    logic                               accept;
    logic                               emit;

    assign s_ready   = !b_valid_reg || b_ready;
    assign accept    = s_valid && s_ready;
    assign fill_inc  = fill_reg + SIZE_W'(1);
    assign emit      = (fill_inc >= eff_size) || s_data.message_end;
    assign b_valid   = b_valid_reg;
    assign b_letters = b_letters_reg;
    assign b_ctl     = b_ctl_reg;

    // A short block is padded out with the letter Z.
    always_comb begin
        for (int j = 0; j < MAX_BLOCK; j++) begin
            if (SIZE_W'(j) == fill_reg) begin
                b_letters_next[j] = s_data.letter_in;
            end else if (SIZE_W'(j) < fill_reg) begin
                b_letters_next[j] = store_reg[j];
            end else begin
                b_letters_next[j] = PAD_LETTER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= emit ? '0 : fill_inc;
            end
            if (accept && emit) begin
                b_valid_reg <= 1'b1;
            end else if (b_ready) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            store_reg[fill_reg[IDX_W-1:0]] <= s_data.letter_in;
        end
        if (accept && emit) begin
            b_letters_reg  <= b_letters_next;
            b_ctl_reg.size <= eff_size;
            b_ctl_reg.last <= s_data.message_end;
        end
    end

    `HCBM_ASSERT_NOW(a_fill_below_max, aclk, aresetn, 1'b1, fill_reg < SIZE_W'(MAX_BLOCK), "Fill count reached the block depth.")
    `HCBM_ASSERT_NEXT(a_block_held, aclk, aresetn, b_valid_reg && !b_ready, b_valid_reg && $stable(b_letters_reg), "Pending block was lost while stalled.")

endmodule
`default_nettype wire

>>> rtl/hcbm_dot.sv
`default_nettype none
module hcbm_dot #(
    parameter int MAX_BLOCK = hcbm_pkg::MAX_BLOCK_DEF,
    parameter int SUM_W     = 12
) (
    input  wire logic                                                aclk,
    input  wire logic                                                aresetn,
    input  wire logic                                                b_valid,
    output logic                                                     b_ready,
    input  wire logic [MAX_BLOCK-1:0][hcbm_pkg::LETTER_W-1:0]        b_letters,
    input  wire hcbm_pkg::blk_ctl_t                                  b_ctl,
    input  wire logic [hcbm_pkg::KEY_ROWS-1:0][hcbm_pkg::KEY_W-1:0]  key_rows,
    output logic                                                     c_valid,
    input  wire logic                                                c_ready,
    output logic [MAX_BLOCK-1:0][SUM_W-1:0]                          c_sums,
    output hcbm_pkg::blk_ctl_t                                       c_ctl
);
    import hcbm_pkg::*;

    localparam int PROD_W = 2 * LETTER_W;

    logic [MAX_BLOCK-1:0][MAX_BLOCK-1:0][PROD_W-1:0] prod;
    logic [MAX_BLOCK-1:0][SUM_W-1:0]                 sum_next;
    logic [MAX_BLOCK-1:0][SUM_W-1:0]                 sums_reg;
    logic                                            c_valid_reg;
    blk_ctl_t                                        c_ctl_reg;

    assign b_ready = !c_valid_reg || c_ready;
    assign c_valid = c_valid_reg;
    assign c_sums  = sums_reg;
    assign c_ctl   = c_ctl_reg;

    always_comb begin
        for (int i = 0; i < MAX_BLOCK; i++) begin
            for (int j = 0; j < MAX_BLOCK; j++) begin
                prod[i][j] = PROD_W'(mod_alpha(key_rows[i][LETTER_W*j +: LETTER_W]))
                           * PROD_W'(mod_alpha(b_letters[j]));
            end
        end
    end

    // Columns past the block size do not take part in the product.
    always_comb begin
        for (int i = 0; i < MAX_BLOCK; i++) begin
            sum_next[i] = '0;
            for (int j = 0; j < MAX_BLOCK; j++) begin
                if (SIZE_W'(j) < b_ctl.size) begin
                    sum_next[i] = sum_next[i] + SUM_W'(prod[i][j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (b_ready) begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid && b_ready) begin
            sums_reg  <= sum_next;
            c_ctl_reg <= b_ctl;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hcbm_serial.sv
`default_nettype none
`include "hill_cipher_block_multiply_defines.svh"
module hcbm_serial #(
    parameter int MAX_BLOCK = hcbm_pkg::MAX_BLOCK_DEF,
    parameter int SUM_W     = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         c_valid,
    output logic                              c_ready,
    input  wire logic [MAX_BLOCK-1:0][SUM_W-1:0] c_sums,
    input  wire hcbm_pkg::blk_ctl_t           c_ctl,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output hcbm_pkg::out_word_t               m_data
);
    import hcbm_pkg::*;

    localparam int IDX_W       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 12;
    localparam int MUL_W       = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 12'd2520;

    logic                               d_valid_reg;
    logic [IDX_W-1:0]                   beat_reg;
    logic [MAX_BLOCK-1:0][LETTER_W-1:0] res_reg;
    logic [SIZE_W-1:0]                  size_reg;
    logic                               last_reg;
    logic                               last_beat;

    // The scaled reciprocal underestimates the quotient by at most one.
    function automatic logic [LETTER_W-1:0] mod_sum(input logic [SUM_W-1:0] s);
        logic [MUL_W-1:0] scaled;
        logic [SUM_W-1:0] quo;
        logic [SUM_W-1:0] rem;
        scaled = MUL_W'(s) * MUL_W'(RECIP);
        quo    = SUM_W'(scaled >> RECIP_SHIFT);
        rem    = s - SUM_W'(quo * SUM_W'(ALPHA));
        if (rem >= SUM_W'(ALPHA)) begin
            rem = rem - SUM_W'(ALPHA);
        end
        return LETTER_W'(rem);
    endfunction

    assign last_beat         = (SIZE_W'(beat_reg) == size_reg - SIZE_W'(1));
    assign c_ready           = !d_valid_reg || (m_ready && last_beat);
    assign m_valid           = d_valid_reg;
    assign m_data.letter_out = res_reg[beat_reg];
    assign m_data.final_out  = last_reg && last_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            beat_reg    <= '0;
        end else if (c_ready) begin
            d_valid_reg <= c_valid;
            beat_reg    <= '0;
        end else if (m_ready) begin
            beat_reg <= beat_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid && c_ready) begin
            for (int i = 0; i < MAX_BLOCK; i++) begin
                res_reg[i] <= mod_sum(c_sums[i]);
            end
            size_reg <= c_ctl.size;
            last_reg <= c_ctl.last;
        end
    end

    `HCBM_ASSERT_NOW(a_letter_range, aclk, aresetn, d_valid_reg, m_data.letter_out < ALPHA, "Result letter is outside the alphabet.")
    `HCBM_ASSERT_NOW(a_beat_range, aclk, aresetn, d_valid_reg, SIZE_W'(beat_reg) < size_reg, "Output beat ran past the block size.")
    `HCBM_ASSERT_NEXT(a_drain, aclk, aresetn, d_valid_reg && m_ready && last_beat && !c_valid, !d_valid_reg, "Result stayed valid after its last word.")

endmodule
`default_nettype wire

>>> rtl/hill_cipher_block_multiply.sv
// A block's first result word is valid after the collect, dot and serial registers.
// With m_ready high: one letter word per cycle sustained; a block emits one word per cycle.
// A short block closed by message_end yields up to MAX_BLOCK words and stalls input meanwhile.
// Reset (aresetn low at a clock edge) empties the pipeline, clears the fill count,
// sets block_size to 2 and all key rows to zero.
`default_nettype none
module hill_cipher_block_multiply #(
    parameter int MAX_BLOCK = hcbm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hcbm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [hcbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire hcbm_pkg::in_word_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output hcbm_pkg::out_word_t                      m_data
);
    import hcbm_pkg::*;

    localparam int SUM_W = $clog2(MAX_BLOCK * (ALPHA - 1) * (ALPHA - 1) + 1);

    logic [SIZE_W-1:0]                  block_size_reg;
    logic [KEY_ROWS-1:0][KEY_W-1:0]     key_row_reg;
    logic [SIZE_W-1:0]                  eff_size;
    logic                               b_valid;
    logic                               b_ready;
    logic [MAX_BLOCK-1:0][LETTER_W-1:0] b_letters;
    blk_ctl_t                           b_ctl;
    logic                               c_valid;
    logic                               c_ready;
    logic [MAX_BLOCK-1:0][SUM_W-1:0]    c_sums;
    blk_ctl_t                           c_ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= SIZE_RST;
            key_row_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BLOCK_SIZE: block_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_KEY_ROW_0:  key_row_reg[0] <= cfg_wdata[KEY_W-1:0];
                CFG_KEY_ROW_1:  key_row_reg[1] <= cfg_wdata[KEY_W-1:0];
                CFG_KEY_ROW_2:  key_row_reg[2] <= cfg_wdata[KEY_W-1:0];
                CFG_KEY_ROW_3:  key_row_reg[3] <= cfg_wdata[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A block size of zero acts as one; sizes above the depth are clamped.
    always_comb begin
        if (block_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (block_size_reg > SIZE_W'(MAX_BLOCK)) begin
            eff_size = SIZE_W'(MAX_BLOCK);
        end else begin
            eff_size = block_size_reg;
        end
    end

    hcbm_collect #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .eff_size  (eff_size),
        .b_valid   (b_valid),
        .b_ready   (b_ready),
        .b_letters (b_letters),
        .b_ctl     (b_ctl)
    );

    hcbm_dot #(
        .MAX_BLOCK (MAX_BLOCK),
        .SUM_W     (SUM_W)
    ) u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .b_valid   (b_valid),
        .b_ready   (b_ready),
        .b_letters (b_letters),
        .b_ctl     (b_ctl),
        .key_rows  (key_row_reg),
        .c_valid   (c_valid),
        .c_ready   (c_ready),
        .c_sums    (c_sums),
        .c_ctl     (c_ctl)
    );

    hcbm_serial #(
        .MAX_BLOCK (MAX_BLOCK),
        .SUM_W     (SUM_W)
    ) u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .c_valid (c_valid),
        .c_ready (c_ready),
        .c_sums  (c_sums),
        .c_ctl   (c_ctl),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
    import hcbm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_ITEMS   = 60;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic                is_reg;
        cfg_index_t          idx;
        logic [KEY_W-1:0]    value;
        in_word_t            word;
        logic                typed;
        logic [LETTER_W-1:0] want;
    } step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;

    logic                  typed_now = 1'b0;
    logic [LETTER_W-1:0]   typed_letter = '0;

    logic [SIZE_W-1:0]     cur_size;
    logic [KEY_W-1:0]      key_row [KEY_ROWS];
    logic [LETTER_W-1:0]   held [MAX_BLOCK_DEF];
    int                    held_count;
    out_word_t             pending_cipher [$];

    bit tx_jitter = 1'b1;
    bit rx_jitter = 1'b1;
    bit hold_req  = 1'b0;

    int unsigned cycle_count   = 0;
    int unsigned letters_sent  = 0;
    int unsigned messages_sent = 0;
    int unsigned words_checked = 0;
    int unsigned reg_writes    = 0;
    int unsigned mismatches    = 0;

    hill_cipher_block_multiply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Gathers one letter and, when the block closes, queues the cipher words it yields.
    function automatic void hill_block_result(input in_word_t w, input logic typed,
                                              input logic [LETTER_W-1:0] want);
        int        n;
        int        sum;
        out_word_t r;
        n = (cur_size == 0) ? 1 : ((cur_size > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : cur_size);
        if (held_count < MAX_BLOCK_DEF) begin
            held[held_count] = w.letter_in;
            held_count++;
        end
        if (held_count < n && !w.message_end) return;
        for (int j = held_count; j < n; j++) held[j] = PAD_LETTER;
        for (int i = 0; i < n; i++) begin
            sum = 0;
            for (int j = 0; j < n; j++) sum += (key_row[i][5*j +: 5] % 26) * held[j];
            r.letter_out = typed ? want : LETTER_W'(sum % 26);
            r.final_out  = w.message_end && (i == n - 1);
            pending_cipher.push_back(r);
        end
        held_count = 0;
    endfunction

    task automatic report_miss(input string what, input int unsigned want,
                               input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on result word %0d: %s expected %0d, got %0d.",
                     words_checked, what, want, got);
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            cur_size = SIZE_RST;
            for (int i = 0; i < KEY_ROWS; i++) key_row[i] = '0;
            for (int i = 0; i < MAX_BLOCK_DEF; i++) held[i] = '0;
            held_count = 0;
            pending_cipher.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_cipher.size() == 0) begin
                    report_miss("unexpected word, letter_out", 0, m_data.letter_out);
                end else begin
                    want = pending_cipher.pop_front();
                    if (m_data.letter_out !== want.letter_out)
                        report_miss("letter_out", want.letter_out, m_data.letter_out);
                    if (m_data.final_out !== want.final_out)
                        report_miss("final_out", want.final_out, m_data.final_out);
                end
                words_checked++;
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_BLOCK_SIZE: cur_size = cfg_wdata[SIZE_W-1:0];
                    CFG_KEY_ROW_0:  key_row[0] = cfg_wdata;
                    CFG_KEY_ROW_1:  key_row[1] = cfg_wdata;
                    CFG_KEY_ROW_2:  key_row[2] = cfg_wdata;
                    CFG_KEY_ROW_3:  key_row[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) hill_block_result(s_data, typed_now, typed_letter);
        end
    end

    // Result side: random short stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic sender_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_letter(input in_word_t w, input logic typed,
                               input logic [LETTER_W-1:0] want);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_data       <= w;
        typed_now    <= typed;
        typed_letter <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        letters_sent++;
        if (w.message_end) messages_sent++;
        if (tx_jitter && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 5)) sender_idle();
    endtask

    // Holds the input side until every queued cipher word is out and the block has settled.
    task automatic drain();
        sender_idle();
        while (pending_cipher.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
    endtask

    function automatic step_t letter_step(input logic [LETTER_W-1:0] letter, input logic last,
                                          input logic typed, input logic [LETTER_W-1:0] want);
        step_t s;
        s = '0;
        s.word.letter_in   = letter;
        s.word.message_end = last;
        s.typed            = typed;
        s.want             = want;
        return s;
    endfunction

    function automatic step_t reg_step(input cfg_index_t idx, input logic [KEY_W-1:0] value);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.value  = value;
        return s;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key_row();
        logic [KEY_W-1:0] row;
        if ($urandom_range(0, 3) == 0) return KEY_W'($urandom());
        for (int j = 0; j < 4; j++) row[5*j +: 5] = LETTER_W'($urandom_range(0, 25));
        return row;
    endfunction

    function automatic logic [LETTER_W-1:0] rand_letter();
        if ($urandom_range(0, 9) == 0) return LETTER_W'($urandom_range(26, 31));
        return LETTER_W'($urandom_range(0, 25));
    endfunction

    initial begin
        step_t               plan [$];
        int unsigned         random_end;
        int                  phase;
        int                  msg_len;
        bit                  mid_change;
        logic [SIZE_W-1:0]   size;
        in_word_t            w;

        // Zero key after reset gives zero words; a one-entry identity key passes letters through.
        plan.push_back(letter_step(5'd0,  1'b0, 1'b1, 5'd0));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b1, 5'd0));
        plan.push_back(letter_step(5'd31, 1'b1, 1'b1, 5'd0));
        plan.push_back(reg_step(CFG_KEY_ROW_0, 20'd1));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd1));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b1, 5'd25));
        plan.push_back(letter_step(5'd31, 1'b0, 1'b1, 5'd5));
        plan.push_back(letter_step(5'd0,  1'b1, 1'b1, 5'd0));
        plan.push_back(reg_step(CFG_KEY_ROW_0, 20'd27));
        plan.push_back(letter_step(5'd13, 1'b0, 1'b1, 5'd13));
        plan.push_back(reg_step(CFG_KEY_ROW_0, 20'hFFFFF));
        plan.push_back(letter_step(5'd31, 1'b0, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd0));
        plan.push_back(letter_step(5'd7,  1'b0, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd7));
        plan.push_back(reg_step(CFG_KEY_ROW_1, 20'hFFFFF));
        plan.push_back(reg_step(CFG_KEY_ROW_2, 20'h5A5A5));
        plan.push_back(reg_step(CFG_KEY_ROW_3, 20'h00000));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd25, 1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd1,  1'b1, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd4));
        plan.push_back(letter_step(5'd2,  1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd3,  1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd4,  1'b0, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd2));
        plan.push_back(letter_step(5'd5,  1'b0, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd3));
        plan.push_back(letter_step(5'd9,  1'b0, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_KEY_ROW_0, 20'h0A4C1));
        plan.push_back(letter_step(5'd10, 1'b1, 1'b0, 5'd0));
        plan.push_back(reg_step(CFG_BLOCK_SIZE, 20'd5));
        plan.push_back(letter_step(5'd0,  1'b0, 1'b0, 5'd0));
        plan.push_back(letter_step(5'd17, 1'b1, 1'b0, 5'd0));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_reg) write_reg(plan[k].idx, plan[k].value);
            else send_letter(plan[k].word, plan[k].typed, plan[k].want);
        end

        random_end = letters_sent + RANDOM_ITEMS;
        phase = 0;
        while (letters_sent < random_end) begin
            phase++;
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = SIZE_W'($urandom_range(5, 7));
                default: size = SIZE_W'($urandom_range(1, 4));
            endcase
            write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(size));
            for (int r = 0; r < KEY_ROWS; r++)
                write_reg(cfg_index_t'(int'(CFG_KEY_ROW_0) + r), rand_key_row());
            if (phase == 3) hold_req = 1'b1;
            repeat ($urandom_range(2, 6)) begin
                rx_jitter  = (letters_sent + TAIL_ITEMS) < random_end;
                tx_jitter  = rx_jitter && (phase != 3);
                msg_len    = $urandom_range(1, 12);
                mid_change = (msg_len > 1) && ($urandom_range(0, 5) == 0);
                for (int k = 0; k < msg_len; k++) begin
                    if (mid_change && k == msg_len / 2) begin
                        if ($urandom_range(0, 1) == 0)
                            write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom_range(1, 4)));
                        else
                            write_reg(cfg_index_t'(int'(CFG_KEY_ROW_0) + $urandom_range(0, 3)),
                                      rand_key_row());
                    end
                    w.letter_in   = rand_letter();
                    w.message_end = (k == msg_len - 1);
                    send_letter(w, 1'b0, '0);
                end
            end
            if (phase % 4 == 0) drain();
        end

        sender_idle();
        while (pending_cipher.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d letters in %0d messages over %0d random phases; %0d register writes.",
                 letters_sent, messages_sent, phase, reg_writes);
        $display("Checked %0d cipher words; block sizes 0 to 7, out-of-range keys and letters, "
                 , words_checked, "mid-block changes and a long output stall were exercised.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
